// ----- rtl/core/ialu_pkg.sv -----
// ialu_pkg: shared types, opcodes and status codes for the 64-bit integer alu
// no dependencies
package ialu_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int OP_W      = 4;
    localparam int ST_W      = 3;
    localparam int DIV_STEPS = DATA_W;

    localparam logic [OP_W-1:0] OP_XOR = 4'd0;
    localparam logic [OP_W-1:0] OP_SHL = 4'd1;
    localparam logic [OP_W-1:0] OP_SHR = 4'd2;
    localparam logic [OP_W-1:0] OP_EQ  = 4'd3;
    localparam logic [OP_W-1:0] OP_NE  = 4'd4;
    localparam logic [OP_W-1:0] OP_GT  = 4'd5;
    localparam logic [OP_W-1:0] OP_GE  = 4'd6;
    localparam logic [OP_W-1:0] OP_LT  = 4'd7;
    localparam logic [OP_W-1:0] OP_LE  = 4'd8;
    localparam logic [OP_W-1:0] OP_SUB = 4'd9;
    localparam logic [OP_W-1:0] OP_ADD = 4'd10;
    localparam logic [OP_W-1:0] OP_MUL = 4'd11;
    localparam logic [OP_W-1:0] OP_DIV = 4'd12;
    localparam logic [OP_W-1:0] OP_MOD = 4'd13;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_DIV_ZERO  = 3'd1;
    localparam logic [ST_W-1:0] ST_DIV_OVF   = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_SHIFT = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_OP    = 3'd4;

    // one word in flight: simple result plus divider state
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [ST_W-1:0]   st;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
        logic              aneg;
        logic              bneg;
    } t_pipe;

    // multiplier partial products
    typedef struct packed {
        logic [DATA_W-1:0] lo_lo;
        logic [HALF_W-1:0] lo_hi;
        logic [HALF_W-1:0] hi_lo;
    } t_mulpp;

endpackage

// ----- rtl/core/ialu_front.sv -----
// ialu_front: first stage, decode, simple ops, error checks, partial products
// depends on ialu_pkg
module ialu_front
    import ialu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_left_operand,
    input  logic [DATA_W-1:0] i_right_operand,
    output t_pipe             o_pipe,
    output t_mulpp            o_pp
);

    t_pipe  r_pipe, n_pipe;
    t_mulpp r_pp, n_pp;
    logic   w_lt, w_gt;
    logic [DATA_W-1:0] a, b;

    assign a    = i_left_operand;
    assign b    = i_right_operand;
    assign w_lt = $signed(a) < $signed(b);
    assign w_gt = $signed(b) < $signed(a);

    always_comb begin
        n_pipe       = '0;
        n_pipe.valid = i_valid;
        n_pipe.op    = i_opcode;
        n_pipe.st    = ST_OK;
        n_pipe.aneg  = a[DATA_W-1];
        n_pipe.bneg  = b[DATA_W-1];
        n_pipe.quo   = a[DATA_W-1] ? (~a + 1'b1) : a;
        n_pipe.dvs   = b[DATA_W-1] ? (~b + 1'b1) : b;
        n_pipe.rem   = '0;
        case (i_opcode)
            OP_XOR: n_pipe.res = a ^ b;
            OP_SHL, OP_SHR: begin
                if (b > DATA_W - 1) begin
                    n_pipe.st = ST_BAD_SHIFT;
                end else if (i_opcode == OP_SHL) begin
                    n_pipe.res = a << b[5:0];
                end else begin
                    n_pipe.res = DATA_W'($signed(a) >>> b[5:0]);
                end
            end
            OP_EQ:  n_pipe.res = DATA_W'(a == b);
            OP_NE:  n_pipe.res = DATA_W'(a != b);
            OP_GT:  n_pipe.res = DATA_W'(w_gt);
            OP_GE:  n_pipe.res = DATA_W'(!w_lt);
            OP_LT:  n_pipe.res = DATA_W'(w_lt);
            OP_LE:  n_pipe.res = DATA_W'(!w_gt);
            OP_SUB: n_pipe.res = a - b;
            OP_ADD: n_pipe.res = a + b;
            OP_MUL: n_pipe.res = '0;
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    n_pipe.st = ST_DIV_ZERO;
                end else if (a == {1'b1, {(DATA_W-1){1'b0}}} && b == '1) begin
                    n_pipe.st = ST_DIV_OVF;
                end
            end
            default: n_pipe.st = ST_BAD_OP;
        endcase
        n_pp.lo_lo = DATA_W'(a[HALF_W-1:0]) * DATA_W'(b[HALF_W-1:0]);
        n_pp.lo_hi = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
        n_pp.hi_lo = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.op   <= n_pipe.op;
            r_pipe.st   <= n_pipe.st;
            r_pipe.res  <= n_pipe.res;
            r_pipe.rem  <= n_pipe.rem;
            r_pipe.quo  <= n_pipe.quo;
            r_pipe.dvs  <= n_pipe.dvs;
            r_pipe.aneg <= n_pipe.aneg;
            r_pipe.bneg <= n_pipe.bneg;
            r_pp        <= n_pp;
        end
    end

    assign o_pipe = r_pipe;
    assign o_pp   = r_pp;

endmodule

// ----- rtl/core/ialu_div_step.sv -----
// ialu_div_step: one restoring division step, registered
// depends on ialu_pkg
module ialu_div_step
    import ialu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_pipe i_pipe,
    output t_pipe o_pipe
);

    t_pipe r_pipe, n_pipe;
    logic [DATA_W:0] w_shift, w_trial;

    always_comb begin
        n_pipe  = i_pipe;
        w_shift = {i_pipe.rem, i_pipe.quo[DATA_W-1]};
        w_trial = w_shift - {1'b0, i_pipe.dvs};
        if (!w_trial[DATA_W]) begin
            n_pipe.rem = w_trial[DATA_W-1:0];
            n_pipe.quo = {i_pipe.quo[DATA_W-2:0], 1'b1};
        end else begin
            n_pipe.rem = w_shift[DATA_W-1:0];
            n_pipe.quo = {i_pipe.quo[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe.valid <= 1'b0;
        end else if (i_en) begin
            r_pipe.valid <= n_pipe.valid;
        end
        if (i_en) begin
            r_pipe.op   <= n_pipe.op;
            r_pipe.st   <= n_pipe.st;
            r_pipe.res  <= n_pipe.res;
            r_pipe.rem  <= n_pipe.rem;
            r_pipe.quo  <= n_pipe.quo;
            r_pipe.dvs  <= n_pipe.dvs;
            r_pipe.aneg <= n_pipe.aneg;
            r_pipe.bneg <= n_pipe.bneg;
        end
    end

    assign o_pipe = r_pipe;

endmodule

// ----- rtl/core/ialu_back.sv -----
// ialu_back: stage before the output register, quotient and remainder sign fix and error zeroing
// depends on ialu_pkg
module ialu_back
    import ialu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_pipe             i_pipe,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_res,
    output logic [ST_W-1:0]   o_st
);

    logic              r_valid;
    logic [DATA_W-1:0] r_res, n_res;
    logic [ST_W-1:0]   r_st;

    always_comb begin
        if (i_pipe.st != ST_OK) begin
            n_res = '0;
        end else if (i_pipe.op == OP_DIV) begin
            n_res = (i_pipe.aneg ^ i_pipe.bneg) ? (~i_pipe.quo + 1'b1) : i_pipe.quo;
        end else if (i_pipe.op == OP_MOD) begin
            n_res = i_pipe.aneg ? (~i_pipe.rem + 1'b1) : i_pipe.rem;
        end else begin
            n_res = i_pipe.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_pipe.valid;
        end
        if (i_en) begin
            r_res <= n_res;
            r_st  <= i_pipe.st;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_st    = r_st;

endmodule

// ----- rtl/core/integer_alu_64bit_top.sv -----
// integer_alu_64bit_top: pipelined signed 64-bit alu with multiply and divide
// an accepted word passes front, multiply, divider steps, back and output register to o_valid
// throughput one word per cycle while o_stall is low; every opcode takes the same path length
// the 64 one-bit restoring divider stages set the depth
// reset (synchronous, active low) clears all valid bits, output and skid valid included
// depends on ialu_pkg, ialu_front, ialu_div_step, ialu_back
module integer_alu_64bit_top
    import ialu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_left_operand,
    input  logic [DATA_W-1:0] i_right_operand,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_alu_result,
    output logic [ST_W-1:0]   o_status
);

    // whole pipe moves together unless the skid word is parked
    logic   w_adv;
    t_pipe  w_front;
    t_mulpp w_pp;
    t_pipe  r_mul, n_mul;
    t_pipe  w_div [0:DIV_STEPS];

    logic              w_last_valid;
    logic [DATA_W-1:0] w_last_res;
    logic [ST_W-1:0]   w_last_st;

    // output register and one-word skid
    logic              r_out_v, r_sk_v;
    logic [DATA_W-1:0] r_out_res, r_sk_res;
    logic [ST_W-1:0]   r_out_st, r_sk_st;
    logic              w_take;

    assign w_adv   = !r_sk_v;
    assign o_stall = r_sk_v;
    assign w_take  = !(r_out_v && i_stall);

    // stage 1: decode, simple ops, magnitudes, partial products
    ialu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_adv),
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_left_operand  (i_left_operand),
        .i_right_operand (i_right_operand),
        .o_pipe          (w_front),
        .o_pp            (w_pp)
    );

    // stage 2: sum partial products, low 64 bits only
    always_comb begin
        n_mul = w_front;
        if (w_front.op == OP_MUL) begin
            n_mul.res = w_pp.lo_lo + {w_pp.lo_hi + w_pp.hi_lo, {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.valid <= 1'b0;
        end else if (w_adv) begin
            r_mul.valid <= n_mul.valid;
        end
        if (w_adv) begin
            r_mul.op   <= n_mul.op;
            r_mul.st   <= n_mul.st;
            r_mul.res  <= n_mul.res;
            r_mul.rem  <= n_mul.rem;
            r_mul.quo  <= n_mul.quo;
            r_mul.dvs  <= n_mul.dvs;
            r_mul.aneg <= n_mul.aneg;
            r_mul.bneg <= n_mul.bneg;
        end
    end

    // stages 3..66: one quotient bit per stage, other ops ride along
    assign w_div[0] = r_mul;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        ialu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_pipe  (w_div[g]),
            .o_pipe  (w_div[g+1])
        );
    end

    // stage 67: sign fix and final select
    ialu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_pipe  (w_div[DIV_STEPS]),
        .o_valid (w_last_valid),
        .o_res   (w_last_res),
        .o_st    (w_last_st)
    );

    // stage 68: output register; a word arriving while the output is
    // stalled parks in the skid, which then freezes the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (w_take) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= w_last_valid;
            end
        end else if (w_adv && w_last_valid) begin
            r_sk_v <= 1'b1;
        end
        if (w_take) begin
            r_out_res <= r_sk_v ? r_sk_res : w_last_res;
            r_out_st  <= r_sk_v ? r_sk_st  : w_last_st;
        end else if (w_adv && w_last_valid) begin
            r_sk_res <= w_last_res;
            r_sk_st  <= w_last_st;
        end
    end

    assign o_valid      = r_out_v;
    assign o_alu_result = r_out_res;
    assign o_status     = r_out_st;

endmodule

// ----- rtl/core/ialu_checker.sv -----
// ialu_checker: port-level assertions for integer_alu_64bit_top, with bind
// depends on ialu_pkg
module ialu_checker
    import ialu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_alu_result,
    input logic [ST_W-1:0]   o_status
);

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_DIV_ZERO ||
                     o_status == ST_DIV_OVF || o_status == ST_BAD_SHIFT ||
                     o_status == ST_BAD_OP))
        else $error("status code out of range");

    // any error gives a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_alu_result == '0))
        else $error("nonzero result with error status");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_alu_result) && $stable(o_status)))
        else $error("stalled result changed");

    // input backpressure only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

endmodule

bind integer_alu_64bit_top ialu_checker u_ialu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_alu_result (o_alu_result),
    .o_status     (o_status)
);

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for integer_alu_64bit_top, queue-fed driver and monitor
// predicts each word in place and compares result and status in order
// depends on ialu_pkg and integer_alu_64bit_top
`timescale 1ns / 100ps

module tb;
    import ialu_pkg::*;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_word_in;

    typedef struct {
        logic [DATA_W-1:0] res;
        logic [ST_W-1:0]   st;
    } t_word_out;

    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};
    localparam int LATENCY = 68;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode;
    logic [DATA_W-1:0] i_left_operand;
    logic [DATA_W-1:0] i_right_operand;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_alu_result;
    logic [ST_W-1:0]   o_status;

    t_word_in  pending_words[$];
    t_word_out expected_results[$];
    int        mismatch_count;
    int        send_gap;
    int        recv_gap;
    int        hold_cycles;     // long receiver hold-off, counted by the monitor
    bit        idle_enable;     // random idling on both sides
    bit        drain_pause;     // sender waits until every result is back

    integer_alu_64bit_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // the predictor: signed alu result and status for one word
    function automatic t_word_out alu_predict(t_word_in w);
        t_word_out r;
        logic signed [DATA_W-1:0] sa;
        logic signed [DATA_W-1:0] sb;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        sa = w.a;
        sb = w.b;
        r.res = '0;
        r.st = ST_OK;
        case (w.op)
            OP_XOR: r.res = w.a ^ w.b;
            OP_SHL, OP_SHR: begin
                if (w.b > 63) begin
                    r.st = ST_BAD_SHIFT;
                end else if (w.op == OP_SHL) begin
                    r.res = w.a << w.b[5:0];
                end else begin
                    r.res = sa >>> w.b[5:0];
                end
            end
            OP_EQ:  r.res = DATA_W'(w.a == w.b);
            OP_NE:  r.res = DATA_W'(w.a != w.b);
            OP_GT:  r.res = DATA_W'(sa > sb);
            OP_GE:  r.res = DATA_W'(sa >= sb);
            OP_LT:  r.res = DATA_W'(sa < sb);
            OP_LE:  r.res = DATA_W'(sa <= sb);
            OP_SUB: r.res = w.a - w.b;
            OP_ADD: r.res = w.a + w.b;
            OP_MUL: r.res = w.a * w.b;
            OP_DIV, OP_MOD: begin
                if (w.b == '0) begin
                    r.st = ST_DIV_ZERO;
                end else if (w.a == MIN_VAL && w.b == NEG_ONE) begin
                    r.st = ST_DIV_OVF;
                end else begin
                    // unsigned magnitudes avoid any simulator quirk at the minimum value
                    ma = w.a[DATA_W-1] ? -w.a : w.a;
                    mb = w.b[DATA_W-1] ? -w.b : w.b;
                    if (w.op == OP_DIV) begin
                        r.res = ma / mb;
                        if (w.a[DATA_W-1] != w.b[DATA_W-1]) r.res = -r.res;
                    end else begin
                        r.res = ma % mb;
                        if (w.a[DATA_W-1]) r.res = -r.res;
                    end
                end
            end
            default: r.st = ST_BAD_OP;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic add_word(logic [OP_W-1:0] op, logic [DATA_W-1:0] a,
                            logic [DATA_W-1:0] b);
        t_word_in w;
        w.op = op;
        w.a = a;
        w.b = b;
        pending_words.push_back(w);
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = MIN_VAL;
            1: v = MAX_VAL;
            2: v = NEG_ONE;
            3: v = DATA_W'($urandom_range(0, 70));
            4: v = -DATA_W'($urandom_range(0, 70));
            5: v = {{32{v[31]}}, v[31:0]};
            default: ;
        endcase
        return v;
    endfunction

    // driver: offers the head of the queue, holds it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            // accepted word leaves the queue, so the head is the next one
            if (i_valid && !o_stall) begin
                void'(pending_words.pop_front());
            end
            if (i_valid && o_stall) begin
                // stalled word stays put
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (drain_pause || pending_words.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                if (idle_enable && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 6);
                    i_valid <= 1'b0;
                end else begin
                    i_opcode <= pending_words[0].op;
                    i_left_operand <= pending_words[0].a;
                    i_right_operand <= pending_words[0].b;
                    expected_results.push_back(alu_predict(pending_words[0]));
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: checks accepted results and drives the receiver stall
    always @(posedge i_clk) begin
        t_word_out exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no expectation waiting");
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_alu_result !== exp_r.res)
                        report_mismatch($sformatf("result %h, expected %h",
                                                  o_alu_result, exp_r.res));
                    if (o_status !== exp_r.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, exp_r.st));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [DATA_W-1:0] edge_vals[6];
        edge_vals = '{64'd0, 64'd1, NEG_ONE, MIN_VAL, MAX_VAL, 64'd63};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_opcode = '0;
        i_left_operand = '0;
        i_right_operand = '0;
        mismatch_count = 0;
        hold_cycles = 0;
        idle_enable = 1'b0;
        drain_pause = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every opcode including the two invalid ones
        for (int op = 0; op < 16; op++) add_word(OP_W'(op), MIN_VAL, NEG_ONE);
        add_word(OP_DIV, 64'd5, 64'd0);
        add_word(OP_MOD, MAX_VAL, 64'd0);
        add_word(OP_MOD, -64'd7, 64'd2);
        add_word(OP_DIV, -64'd7, 64'd2);
        add_word(OP_SHL, 64'd3, 64'd64);
        add_word(OP_SHR, MIN_VAL, 64'd63);
        add_word(OP_SHL, MAX_VAL, 64'd1);
        add_word(OP_SHR, 64'd1, NEG_ONE);
        add_word(OP_MUL, MAX_VAL, MAX_VAL);

        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 200; i++) add_word(OP_W'($urandom_range(0, 15)),
                                               rand_operand(), rand_operand());
        hold_cycles = 150;
        wait (pending_words.size() == 0);

        // pause until every result has come back
        drain_pause = 1'b1;
        wait (expected_results.size() == 0);
        drain_pause = 1'b0;

        idle_enable = 1'b1;
        for (int i = 0; i < 700; i++) begin
            add_word(OP_W'($urandom_range(0, 15)),
                     ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 5)]
                                                 : rand_operand(),
                     ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 5)]
                                                 : rand_operand());
        end
        wait (pending_words.size() == 0);

        // last part with no idling
        idle_enable = 1'b0;
        for (int i = 0; i < 180; i++) add_word(OP_W'($urandom_range(0, 15)),
                                               rand_operand(), rand_operand());
        wait (pending_words.size() == 0);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ialu_pkg.sv
rtl/core/ialu_front.sv
rtl/core/ialu_div_step.sv
rtl/core/ialu_back.sv
rtl/core/integer_alu_64bit_top.sv
rtl/core/ialu_checker.sv
tb/sv/tb.sv
